// ===== hdl/wait_queue_with_remove_and_cursor_macros.svh =====
// Assertion macros for the wait queue block.
// Used by the top level; they expand to nothing when SYNTHESIS is defined.
`ifndef WAIT_QUEUE_WITH_REMOVE_AND_CURSOR_MACROS_SVH
`define WAIT_QUEUE_WITH_REMOVE_AND_CURSOR_MACROS_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define WQRC_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("wait queue check failed");
// Check a consequence in the same cycle.
`define WQRC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wait queue check failed");
// Check a consequence in the next cycle.
`define WQRC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wait queue check failed");
`else
`define WQRC_ASSERT_ALWAYS(lbl, expr)
`define WQRC_ASSERT_IMP(lbl, ante, cons)
`define WQRC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/wqrc_pkg.sv =====
// Types and codes shared by the wait queue modules.
// No dependencies.
package wqrc_pkg;

    typedef enum logic [2:0] {
        OP_PUSH         = 3'd0,
        OP_POP          = 3'd1,
        OP_REMOVE       = 3'd2,
        OP_CURSOR_RESET = 3'd3,
        OP_CURSOR_STEP  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_COMPACT
    } t_state;

    typedef struct packed {
        logic [7:0]  sem_id;
        logic [7:0]  thread_id;
        logic [15:0] wait_limit;
    } t_entry;

    // Broadcast commands from the controller to every cell.
    typedef struct packed {
        logic mark;
        logic compact;
        logic pop;
    } t_cell_ctl;

endpackage

// ===== hdl/wqrc_chan_if.sv =====
// Valid/ready channels for queue commands and queue responses.
// No dependencies.
interface wqrc_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [7:0]  sem_id;
    logic [7:0]  thread_id;
    logic [15:0] wait_limit;

    modport source (output valid, output op, output sem_id, output thread_id,
                    output wait_limit, input ready);
    modport sink   (input valid, input op, input sem_id, input thread_id,
                    input wait_limit, output ready);
endinterface

interface wqrc_rsp_if #(
    parameter int COUNT_W = 5
);
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [7:0]         out_sem_id;
    logic [7:0]         out_thread_id;
    logic [15:0]        out_wait_limit;
    logic [COUNT_W-1:0] entry_count;
    logic               cursor_has_next;

    modport source (output valid, output status, output out_sem_id, output out_thread_id,
                    output out_wait_limit, output entry_count, output cursor_has_next,
                    input ready);
    modport sink   (input valid, input status, input out_sem_id, input out_thread_id,
                    input out_wait_limit, input entry_count, input cursor_has_next,
                    output ready);
endinterface

// ===== hdl/wqrc_cell.sv =====
// One queue slot: holds an entry and a delete mark, shifts from its right neighbor.
// Depends on wqrc_pkg.
module wqrc_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wqrc_pkg::t_cell_ctl i_ctl,
    input  logic [7:0]          i_key,
    input  logic                i_wr_sel,
    input  wqrc_pkg::t_entry    i_wr_entry,
    input  logic                i_live,
    input  logic                i_prefix,
    input  wqrc_pkg::t_entry    i_nbr,
    input  logic                i_nbr_dead,
    output wqrc_pkg::t_entry    o_entry,
    output logic                o_dead,
    output logic                o_prefix
);
    wqrc_pkg::t_entry r_entry;
    logic             r_dead;
    logic             w_shift;

    // a marked slot at or left of here pulls the whole suffix one place left
    assign w_shift  = i_prefix | r_dead;
    assign o_prefix = w_shift;
    assign o_entry  = r_entry;
    assign o_dead   = r_dead;

    always_ff @(posedge i_clk) begin
        if (i_wr_sel) begin
            r_entry <= i_wr_entry;
        end else if (i_ctl.pop || (i_ctl.compact && w_shift)) begin
            r_entry <= i_nbr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead <= 1'b0;
        end else if (i_ctl.mark) begin
            r_dead <= i_live && (r_entry.thread_id == i_key);
        end else if (i_ctl.compact && w_shift) begin
            r_dead <= i_nbr_dead;
        end else if (i_ctl.pop || i_wr_sel) begin
            r_dead <= 1'b0;
        end
    end

endmodule

// ===== hdl/wait_queue_with_remove_and_cursor.sv =====
// Top level of the wait queue: controller, occupancy and cursor, row of slot cells.
// Depends on wqrc_pkg, wqrc_chan_if, wqrc_cell and the assertion macro header.
//
//  channel  | dir | payload
//  ---------+-----+----------------------------------------------------------
//  i_cmd    | in  | op, sem_id, thread_id, wait_limit
//  o_rsp    | out | status, out_sem_id, out_thread_id, out_wait_limit,
//           |     | entry_count, cursor_has_next
//
// Push, pop, cursor reset and cursor step take the transfer in idle, then execute
// and load the response register.
// Remove marks the matching entries, then shifts the cell row once per deleted
// entry, then loads the response.
// Synchronous reset empties the queue and parks the cursor past the end.
// A response held by o_rsp.ready stalls only the final step of the next command.
`include "wait_queue_with_remove_and_cursor_macros.svh"
module wait_queue_with_remove_and_cursor #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wqrc_cmd_if.sink    i_cmd,
    wqrc_rsp_if.source  o_rsp
);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W = $clog2(QUEUE_DEPTH);

    wqrc_pkg::t_state    r_state, n_state;
    logic [CNT_W-1:0]    r_occ, n_occ;
    logic [CNT_W-1:0]    r_cur, n_cur;

    logic [2:0]          r_op;
    wqrc_pkg::t_entry    r_item;

    logic                r_out_valid, n_out_valid;
    wqrc_pkg::t_status   r_out_status;
    wqrc_pkg::t_entry    r_out_entry;
    logic [CNT_W-1:0]    r_out_cnt;
    logic                r_out_next;

    logic                w_load;
    wqrc_pkg::t_status   w_res_status;
    wqrc_pkg::t_entry    w_res_entry;
    logic                w_out_free;
    logic                w_push;
    wqrc_pkg::t_cell_ctl w_ctl;

    wqrc_pkg::t_entry    w_cell_q [QUEUE_DEPTH];
    wqrc_pkg::t_entry    w_nbr    [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_dead;
    logic [QUEUE_DEPTH-1:0] w_nbr_dead;
    logic [QUEUE_DEPTH-1:0] w_live;
    logic [QUEUE_DEPTH-1:0] w_wr_sel;
    logic [QUEUE_DEPTH-1:0] w_prefix_before;
    logic [QUEUE_DEPTH:0]   w_prefix;
    logic                w_any_dead;
    logic [IDX_W-1:0]    w_cidx;

    assign i_cmd.ready = (r_state == wqrc_pkg::S_IDLE);
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_cidx      = IDX_W'(r_cur - 1'b1);
    assign w_any_dead  = w_prefix[QUEUE_DEPTH];
    assign w_prefix[0] = 1'b0;
    assign w_prefix_before = w_prefix[QUEUE_DEPTH-1:0];

    // cell row
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        assign w_live[i]   = (CNT_W'(i) < r_occ);
        assign w_wr_sel[i] = w_push && (r_occ == CNT_W'(i));
        if (i == QUEUE_DEPTH - 1) begin : g_last
            assign w_nbr[i]      = '0;
            assign w_nbr_dead[i] = 1'b0;
        end else begin : g_mid
            assign w_nbr[i]      = w_cell_q[i+1];
            assign w_nbr_dead[i] = w_dead[i+1];
        end

        wqrc_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_key      (r_item.thread_id),
            .i_wr_sel   (w_wr_sel[i]),
            .i_wr_entry (r_item),
            .i_live     (w_live[i]),
            .i_prefix   (w_prefix[i]),
            .i_nbr      (w_nbr[i]),
            .i_nbr_dead (w_nbr_dead[i]),
            .o_entry    (w_cell_q[i]),
            .o_dead     (w_dead[i]),
            .o_prefix   (w_prefix[i+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wqrc_pkg::S_IDLE;
            r_occ       <= '0;
            r_cur       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_cur       <= n_cur;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_op                <= i_cmd.op;
            r_item.sem_id       <= i_cmd.sem_id;
            r_item.thread_id    <= i_cmd.thread_id;
            r_item.wait_limit   <= i_cmd.wait_limit;
        end
        if (w_load) begin
            r_out_status <= w_res_status;
            r_out_entry  <= w_res_entry;
            r_out_cnt    <= n_occ;
            r_out_next   <= (n_cur != '0);
        end
    end

    always_comb begin
        n_state      = r_state;
        n_occ        = r_occ;
        n_cur        = r_cur;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        w_load       = 1'b0;
        w_push       = 1'b0;
        w_ctl        = '0;
        w_res_status = wqrc_pkg::STATUS_OK;
        w_res_entry  = '0;

        case (r_state)
            wqrc_pkg::S_IDLE: begin
                if (i_cmd.valid) begin
                    n_state = wqrc_pkg::S_EXEC;
                end
            end
            wqrc_pkg::S_EXEC: begin
                if (r_op == wqrc_pkg::OP_REMOVE) begin
                    w_ctl.mark = 1'b1;
                    n_state    = wqrc_pkg::S_COMPACT;
                end else if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = wqrc_pkg::S_IDLE;
                    case (r_op)
                        wqrc_pkg::OP_PUSH: begin
                            if (r_occ == CNT_W'(QUEUE_DEPTH)) begin
                                w_res_status = wqrc_pkg::STATUS_FULL;
                            end else begin
                                w_push = 1'b1;
                                n_occ  = r_occ + 1'b1;
                            end
                        end
                        wqrc_pkg::OP_POP: begin
                            if (r_occ == '0) begin
                                w_res_status = wqrc_pkg::STATUS_EMPTY;
                            end else begin
                                w_res_entry = w_cell_q[0];
                                w_ctl.pop   = 1'b1;
                                n_occ       = r_occ - 1'b1;
                                // cursor on the head stays on the new head, or parks past the end if none is left
                                if (r_cur > CNT_W'(1)) begin
                                    n_cur = r_cur - 1'b1;
                                end else if (r_cur == CNT_W'(1) && r_occ == CNT_W'(1)) begin
                                    n_cur = '0;
                                end
                            end
                        end
                        wqrc_pkg::OP_CURSOR_RESET: begin
                            n_cur = (r_occ != '0) ? CNT_W'(1) : '0;
                        end
                        wqrc_pkg::OP_CURSOR_STEP: begin
                            if (r_cur == '0) begin
                                w_res_status = wqrc_pkg::STATUS_EMPTY;
                            end else begin
                                w_res_entry = w_cell_q[w_cidx];
                                n_cur       = (r_cur < r_occ) ? r_cur + 1'b1 : '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            wqrc_pkg::S_COMPACT: begin
                if (w_any_dead) begin
                    // drop the leftmost marked entry; a cursor right of it follows its entry
                    w_ctl.compact = 1'b1;
                    n_occ         = r_occ - 1'b1;
                    if (r_cur != '0 && w_prefix_before[w_cidx]) begin
                        n_cur = r_cur - 1'b1;
                    end
                end else if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = wqrc_pkg::S_IDLE;
                    if (r_cur > r_occ) begin
                        n_cur = '0;
                    end
                end
            end
            default: begin
                n_state = wqrc_pkg::S_IDLE;
            end
        endcase

        if (w_load) begin
            n_out_valid = 1'b1;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_out_status;
    assign o_rsp.out_sem_id      = r_out_entry.sem_id;
    assign o_rsp.out_thread_id   = r_out_entry.thread_id;
    assign o_rsp.out_wait_limit  = r_out_entry.wait_limit;
    assign o_rsp.entry_count     = r_out_cnt;
    assign o_rsp.cursor_has_next = r_out_next;

    `WQRC_ASSERT_ALWAYS(a_occ_bound, r_occ <= CNT_W'(QUEUE_DEPTH))
    `WQRC_ASSERT_IMP(a_cursor_in_range, r_state == wqrc_pkg::S_IDLE, r_cur <= r_occ)
    `WQRC_ASSERT_NXT(a_compact_drops_one, (r_state == wqrc_pkg::S_COMPACT) && w_any_dead, r_occ == $past(r_occ) - 1'b1)
    `WQRC_ASSERT_ALWAYS(a_marks_live_only, (w_dead & ~w_live) == '0)

endmodule

// ===== test/tb_wait_queue_with_remove_and_cursor.sv =====
// Self-checking bench for the wait queue: push, pop, remove by thread and cursor walks.
// Depends on wqrc_pkg, the wqrc_cmd_if / wqrc_rsp_if channels and the top level.
// Expected responses come from a behavioral queue model updated at each command transfer.
`timescale 1ns / 1ps
module tb_wait_queue_with_remove_and_cursor;

    localparam int QDEPTH      = 16;
    localparam int COUNT_W     = $clog2(QDEPTH + 1);
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 40;
    localparam int CYCLE_LIMIT = 400000;
    // op codes that the block ignores
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [2:0]        op;
        wqrc_pkg::t_entry  ent;
    } t_queue_cmd;

    typedef struct packed {
        wqrc_pkg::t_status    status;
        wqrc_pkg::t_entry     ent;
        logic [COUNT_W-1:0]   count;
        logic                 has_next;
    } t_queue_rsp;

    logic i_clk;
    logic i_rst_n;

    wqrc_cmd_if                      cmd_chan ();
    wqrc_rsp_if #(.COUNT_W(COUNT_W)) rsp_chan ();

    wait_queue_with_remove_and_cursor #(
        .QUEUE_DEPTH(QDEPTH)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_chan),
        .o_rsp   (rsp_chan)
    );

    // queue model state
    wqrc_pkg::t_entry slots [QDEPTH];
    int          fill_count;
    int          cursor_slot;   // 0 is past end, k is slot k-1

    t_queue_cmd  cmd_pending [$];
    t_queue_rsp  rsp_expected [$];
    int          err_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_start;
    int          hold_left;
    int          cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_queue_rsp predict_queue_op(input t_queue_cmd c);
        t_queue_rsp r;
        int         i;
        int         kept;
        int         new_cur;
        bit         cur_set;
        r = '0;
        r.status = wqrc_pkg::STATUS_OK;
        if (cursor_slot > fill_count)
            cursor_slot = 0;
        case (c.op)
            wqrc_pkg::OP_PUSH: begin
                if (fill_count >= QDEPTH) begin
                    r.status = wqrc_pkg::STATUS_FULL;
                end else begin
                    slots[fill_count] = c.ent;
                    fill_count++;
                end
            end
            wqrc_pkg::OP_POP: begin
                if (fill_count == 0) begin
                    r.status = wqrc_pkg::STATUS_EMPTY;
                end else begin
                    r.ent = slots[0];
                    for (i = 1; i < fill_count; i++)
                        slots[i - 1] = slots[i];
                    fill_count--;
                    if (cursor_slot > 1)
                        cursor_slot--;
                    else if (cursor_slot == 1 && fill_count == 0)
                        cursor_slot = 0;
                end
            end
            wqrc_pkg::OP_REMOVE: begin
                kept = 0;
                new_cur = 0;
                cur_set = 1'b0;
                for (i = 0; i < fill_count; i++) begin
                    if (slots[i].thread_id != c.ent.thread_id) begin
                        // cursor lands on the first survivor at or after its old slot
                        if (!cur_set && cursor_slot != 0 && i + 1 >= cursor_slot) begin
                            new_cur = kept + 1;
                            cur_set = 1'b1;
                        end
                        slots[kept] = slots[i];
                        kept++;
                    end
                end
                fill_count = kept;
                cursor_slot = cur_set ? new_cur : 0;
            end
            wqrc_pkg::OP_CURSOR_RESET: begin
                cursor_slot = (fill_count > 0) ? 1 : 0;
            end
            wqrc_pkg::OP_CURSOR_STEP: begin
                if (cursor_slot == 0) begin
                    r.status = wqrc_pkg::STATUS_EMPTY;
                end else begin
                    r.ent = slots[cursor_slot - 1];
                    cursor_slot = (cursor_slot < fill_count) ? cursor_slot + 1 : 0;
                end
            end
            default: ;
        endcase
        r.count = COUNT_W'(fill_count);
        r.has_next = (cursor_slot != 0);
        return r;
    endfunction

    task automatic add_queue_cmd(input logic [2:0] op, input logic [7:0] sem,
                                 input logic [7:0] thr, input logic [15:0] wl);
        t_queue_cmd c;
        c.op = op;
        c.ent.sem_id = sem;
        c.ent.thread_id = thr;
        c.ent.wait_limit = wl;
        cmd_pending.push_back(c);
    endtask

    // Mostly pushes and cursor walks over a small set of thread ids so that
    // removes hit; the push share swings so the queue runs both full and empty.
    task automatic add_random_ops(input int n);
        logic [7:0] thread_pool [6];
        logic [2:0] op;
        logic [7:0] thr;
        int         push_pct;
        int         roll;
        int         k;
        push_pct = 50;
        for (k = 0; k < 6; k++)
            thread_pool[k] = 8'($urandom_range(0, 255));
        for (k = 0; k < n; k++) begin
            if (k % 24 == 0) begin
                case ($urandom_range(0, 2))
                    0: push_pct = 85;
                    1: push_pct = 55;
                    default: push_pct = 25;
                endcase
            end
            roll = $urandom_range(0, 99);
            if (roll < push_pct) begin
                op = wqrc_pkg::OP_PUSH;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 30)
                    op = wqrc_pkg::OP_POP;
                else if (roll < 50)
                    op = wqrc_pkg::OP_REMOVE;
                else if (roll < 65)
                    op = wqrc_pkg::OP_CURSOR_RESET;
                else if (roll < 97)
                    op = wqrc_pkg::OP_CURSOR_STEP;
                else
                    op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
            end
            if ($urandom_range(0, 4) == 0)
                thr = 8'($urandom_range(0, 255));
            else
                thr = thread_pool[$urandom_range(0, 5)];
            add_queue_cmd(op, 8'($urandom_range(0, 255)), thr, 16'($urandom_range(0, 65535)));
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (cmd_pending.size() != 0 || rsp_expected.size() != 0);
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            err_count++;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endtask

    // command driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_chan.valid <= 1'b0;
        end else begin
            if (cmd_chan.valid && cmd_chan.ready)
                rsp_expected.push_back(predict_queue_op(cmd_pending.pop_front()));
            if (!cmd_chan.valid || cmd_chan.ready) begin
                if (cmd_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    cmd_chan.valid      <= 1'b1;
                    cmd_chan.op         <= cmd_pending[0].op;
                    cmd_chan.sem_id     <= cmd_pending[0].ent.sem_id;
                    cmd_chan.thread_id  <= cmd_pending[0].ent.thread_id;
                    cmd_chan.wait_limit <= cmd_pending[0].ent.wait_limit;
                end else begin
                    cmd_chan.valid <= 1'b0;
                end
            end
        end
    end

    // response monitor
    always @(posedge i_clk) begin : rsp_monitor
        t_queue_rsp want_rsp;
        t_queue_rsp got_rsp;
        if (!i_rst_n) begin
            rsp_chan.ready <= 1'b0;
        end else begin
            if (rsp_chan.valid && rsp_chan.ready) begin
                got_rsp = {rsp_chan.status, rsp_chan.out_sem_id, rsp_chan.out_thread_id,
                           rsp_chan.out_wait_limit, rsp_chan.entry_count,
                           rsp_chan.cursor_has_next};
                if (rsp_expected.size() == 0) begin
                    err_count++;
                    $display("%0t: response expected none got %0h", $time, got_rsp);
                end else begin
                    want_rsp = rsp_expected.pop_front();
                    compare_field("status", want_rsp.status, got_rsp.status);
                    compare_field("out_sem_id", want_rsp.ent.sem_id, got_rsp.ent.sem_id);
                    compare_field("out_thread_id", want_rsp.ent.thread_id,
                                  got_rsp.ent.thread_id);
                    compare_field("out_wait_limit", want_rsp.ent.wait_limit,
                                  got_rsp.ent.wait_limit);
                    compare_field("entry_count", want_rsp.count, got_rsp.count);
                    compare_field("cursor_has_next", want_rsp.has_next, got_rsp.has_next);
                end
            end
            if (hold_start) begin
                hold_left = LONG_HOLD;
                hold_start = 1'b0;
            end
            // hold off long enough for the block to back up into its input
            if (hold_left > 0) begin
                hold_left--;
                rsp_chan.ready <= 1'b0;
            end else begin
                rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_wait_queue_with_remove_and_cursor: done, errors");
            $finish;
        end
    end

    initial begin : stimulus
        int k;
        i_rst_n = 1'b0;
        cmd_chan.valid = 1'b0;
        cmd_chan.op = wqrc_pkg::OP_PUSH;
        cmd_chan.sem_id = '0;
        cmd_chan.thread_id = '0;
        cmd_chan.wait_limit = '0;
        rsp_chan.ready = 1'b0;
        fill_count = 0;
        cursor_slot = 0;
        err_count = 0;
        hold_start = 1'b0;
        hold_left = 0;
        cycle_count = 0;
        send_idle_pct = 36;
        recv_idle_pct = 83;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty queue: pop and step find nothing
        add_queue_cmd(wqrc_pkg::OP_POP, 8'hA5, 8'h3C, 16'h1234);
        add_queue_cmd(wqrc_pkg::OP_CURSOR_STEP, 8'h5A, 8'hC3, 16'h4321);
        add_queue_cmd(wqrc_pkg::OP_CURSOR_RESET, 8'h00, 8'h00, 16'h0000);
        add_queue_cmd(wqrc_pkg::OP_REMOVE, 8'h00, 8'h00, 16'h0000);
        add_queue_cmd(wqrc_pkg::OP_PUSH, 8'h00, 8'h00, 16'h0000);
        add_queue_cmd(wqrc_pkg::OP_PUSH, 8'hFF, 8'hFF, 16'hFFFF);
        for (k = 0; k < QDEPTH - 2; k++)
            add_queue_cmd(wqrc_pkg::OP_PUSH, 8'(k * 17), k[0] ? 8'h5A : 8'(k),
                          16'(16'h8000 | k));
        // full: push is dropped
        add_queue_cmd(wqrc_pkg::OP_PUSH, 8'h11, 8'h22, 16'h3333);
        add_queue_cmd(wqrc_pkg::OP_CURSOR_RESET, 8'h00, 8'h00, 16'h0000);
        add_queue_cmd(wqrc_pkg::OP_CURSOR_STEP, 8'h00, 8'h00, 16'h0000);
        add_queue_cmd(wqrc_pkg::OP_CURSOR_STEP, 8'h00, 8'h00, 16'h0000);
        add_queue_cmd(wqrc_pkg::OP_POP, 8'h00, 8'h00, 16'h0000);
        // pop with the cursor on the head
        add_queue_cmd(wqrc_pkg::OP_CURSOR_RESET, 8'h00, 8'h00, 16'h0000);
        add_queue_cmd(wqrc_pkg::OP_POP, 8'h00, 8'h00, 16'h0000);
        add_queue_cmd(wqrc_pkg::OP_CURSOR_STEP, 8'h00, 8'h00, 16'h0000);
        // remove deletes the entry under the cursor
        add_queue_cmd(wqrc_pkg::OP_REMOVE, 8'hFF, 8'h5A, 16'hFFFF);
        add_queue_cmd(OP_SPARE_FIRST, 8'hFF, 8'hFF, 16'hFFFF);
        add_queue_cmd(OP_SPARE_LAST, 8'h00, 8'h00, 16'h0000);
        add_queue_cmd(wqrc_pkg::OP_REMOVE, 8'h00, 8'hEE, 16'h0000);
        add_random_ops(270);
        wait_drained();

        send_idle_pct = 83;
        recv_idle_pct = 36;
        add_random_ops(130);
        // pause the sender until every response is back
        wait_drained();
        add_random_ops(140);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random_ops(270);
        hold_start = 1'b1;
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);

        if (err_count == 0)
            $display("tb_wait_queue_with_remove_and_cursor: done, clean");
        else
            $display("tb_wait_queue_with_remove_and_cursor: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/wqrc_pkg.sv
hdl/wqrc_chan_if.sv
hdl/wqrc_cell.sv
hdl/wait_queue_with_remove_and_cursor.sv
test/tb_wait_queue_with_remove_and_cursor.sv
